/* design/ursp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ursp_pkg: shared types and constants of the UPS status reply parser
// Command and status groups between controller and datapath, result codes.
// ---------------------------------------------------------------------------
package ursp_pkg;

	localparam int NumFieldsDefault = 7;
	localparam int MinReplyDefault  = 46;
	localparam int KeptFields       = 7;
	localparam int BatteryField     = 5;
	localparam logic [19:0] ValueMax = 20'd999999;
	localparam logic [19:0] AccCap   = 20'd1000000;

	localparam logic [2:0] RES_OK      = 3'd0;
	localparam logic [2:0] RES_SHORT   = 3'd1;
	localparam logic [2:0] RES_BADSTRT = 3'd2;
	localparam logic [2:0] RES_MISSING = 3'd3;
	localparam logic [2:0] RES_BADSTAT = 3'd4;

	localparam logic [1:0] REG_PACK  = 2'd0;
	localparam logic [1:0] REG_LOW   = 2'd1;
	localparam logic [1:0] REG_HIGH  = 2'd2;
	localparam logic [1:0] REG_CHGEN = 2'd3;

	localparam logic [1:0] MODE_NONE   = 2'd0;
	localparam logic [1:0] MODE_TRIM   = 2'd1;
	localparam logic [1:0] MODE_BYPASS = 2'd2;
	localparam logic [1:0] MODE_BOOST  = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic step;  // take the input word
		logic fin;   // close an open token
		logic eval;  // result code, commit plain fields, battery product
		logic sat;   // battery scaling
		logic chg;   // charge setup
		logic div;   // one divider step
		logic cls;   // status word and regulation
		logic clr;   // result taken, clear reply state
	} ursp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic reject;    // short or bad start
		logic div_start; // charge needs the divider
		logic div_last;  // final divider step
	} ursp_sts_t;

endpackage
`default_nettype wire

/* design/ups_status_reply_parser_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ups_status_reply_parser_unit: UPS status reply parser
// Parses a reply byte stream into fixed-point fields, battery charge,
// status word and regulation mode.
// ---------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   reply_byte, reply_end
// out      output     out_valid/out_stall result_code .. regulation_mode
// cfg      input      cfg_we              cfg_index, cfg_data
//
// One cycle per reply byte while input is not stalled. After the end byte
// the sequencer walks its commit steps, including the bit-serial charge
// divider when an estimate is computed (only fin and eval for a short or
// bad-start reply) before the result shows; input stalls until it is taken.
// Reset clears all parser state and loads the configuration defaults.
// ---------------------------------------------------------------------------
module ups_status_reply_parser_unit #(
	parameter int NUM_FIELDS      = ursp_pkg::NumFieldsDefault,
	parameter int MIN_REPLY_BYTES = ursp_pkg::MinReplyDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  reply_byte,
	input  wire logic        reply_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       result_code,
	output logic [19:0]      line_voltage,
	output logic [19:0]      fault_voltage,
	output logic [19:0]      out_voltage,
	output logic [19:0]      load_level,
	output logic [19:0]      line_frequency,
	output logic [19:0]      battery_volts,
	output logic [19:0]      temperature_level,
	output logic [6:0]       charge_percent,
	output logic             charge_known,
	output logic [7:0]       status_word,
	output logic [1:0]       regulation_mode
);
	import ursp_pkg::*;

	ursp_cmd_t cmd;
	ursp_sts_t sts;

	ursp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.reply_end (reply_end),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ursp_dp #(
		.NUM_FIELDS      (NUM_FIELDS),
		.MIN_REPLY_BYTES (MIN_REPLY_BYTES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.reply_byte        (reply_byte),
		.cmd               (cmd),
		.sts               (sts),
		.result_code       (result_code),
		.line_voltage      (line_voltage),
		.fault_voltage     (fault_voltage),
		.out_voltage       (out_voltage),
		.load_level        (load_level),
		.line_frequency    (line_frequency),
		.battery_volts     (battery_volts),
		.temperature_level (temperature_level),
		.charge_percent    (charge_percent),
		.charge_known      (charge_known),
		.status_word       (status_word),
		.regulation_mode   (regulation_mode)
	);

endmodule
`default_nettype wire

/* design/ursp_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ursp_ctrl: reply parser sequencer
// Takes words until the end mark, then walks the commit steps and holds
// the result until the output side takes it.
// ---------------------------------------------------------------------------
module ursp_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                reply_end,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire logic                out_stall,
	input  wire ursp_pkg::ursp_sts_t sts,
	output ursp_pkg::ursp_cmd_t      cmd
);
	import ursp_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_FIN  = 8'b0000_0010,
		S_EVAL = 8'b0000_0100,
		S_SAT  = 8'b0000_1000,
		S_CHG  = 8'b0001_0000,
		S_DIV  = 8'b0010_0000,
		S_CLS  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} ursp_state_t;

	ursp_state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.step = 1'b1;
					if (reply_end) state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.reject ? S_OUT : S_SAT;
			end
			S_SAT: begin
				cmd.sat = 1'b1;
				state_d = S_CHG;
			end
			S_CHG: begin
				cmd.chg = 1'b1;
				state_d = sts.div_start ? S_DIV : S_CLS;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_last) state_d = S_CLS;
			end
			S_CLS: begin
				cmd.cls = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					cmd.clr = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

/* design/ursp_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ursp_dp: reply parser datapath
// Token parsing, pending and committed fields, battery scaling, serial
// charge divider, regulation classifier and configuration registers.
// ---------------------------------------------------------------------------
module ursp_dp #(
	parameter int NUM_FIELDS      = ursp_pkg::NumFieldsDefault,
	parameter int MIN_REPLY_BYTES = ursp_pkg::MinReplyDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [19:0]         cfg_data,
	input  wire logic [7:0]          reply_byte,
	input  wire ursp_pkg::ursp_cmd_t cmd,
	output ursp_pkg::ursp_sts_t      sts,
	output logic [2:0]               result_code,
	output logic [19:0]              line_voltage,
	output logic [19:0]              fault_voltage,
	output logic [19:0]              out_voltage,
	output logic [19:0]              load_level,
	output logic [19:0]              line_frequency,
	output logic [19:0]              battery_volts,
	output logic [19:0]              temperature_level,
	output logic [6:0]               charge_percent,
	output logic                     charge_known,
	output logic [7:0]               status_word,
	output logic [1:0]               regulation_mode
);
	import ursp_pkg::*;

	localparam logic [3:0] NumF   = 4'(NUM_FIELDS);
	localparam logic [6:0] MinLen = 7'(MIN_REPLY_BYTES);

	// configuration
	logic [7:0]  pack_q;
	logic [19:0] low_q, high_q;
	logic        chgen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_q  <= 8'd2;
			low_q   <= '0;
			high_q  <= '0;
			chgen_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PACK:  pack_q  <= cfg_data[7:0];
				REG_LOW:   low_q   <= cfg_data;
				REG_HIGH:  high_q  <= cfg_data;
				REG_CHGEN: chgen_q <= cfg_data[0];
				default:   pack_q  <= pack_q;
			endcase
		end
	end

	// reply state
	logic [19:0] committed_q [KeptFields];
	logic [19:0] pending_q [KeptFields];
	logic [6:0]  pvalid_q;
	logic [6:0]  count_q;
	logic [3:0]  tok_q;
	logic [19:0] acc_q;
	logic        f_in_q, f_bad_q, f_dot_q, f_stop_q;
	logic [1:0]  frac_q;
	logic [7:0]  work_q;
	logic [3:0]  run_q;
	logic        sstop_q, start_q;
	logic [2:0]  code_q;
	logic [7:0]  capture_q;
	logic [7:0]  charge_q;
	logic [1:0]  mode_q;
	logic [27:0] prod_s1;
	logic [27:0] num_q;
	logic [20:0] den_q;
	logic [20:0] rem_q;
	logic [6:0]  quo_q;
	logic [4:0]  dcnt_q;

	// parse step, next values
	logic [3:0]  n_tok;
	logic [19:0] n_acc;
	logic        n_in, n_bad, n_dot, n_stop;
	logic [1:0]  n_frac;
	logic [7:0]  n_work;
	logic [3:0]  n_run;
	logic        n_sstop, n_start;
	logic        wr_en;
	logic [2:0]  wr_idx;
	logic [19:0] wr_val;
	logic        do_fin, is_sep, is_digit;
	logic [3:0]  dig;
	logic [23:0] acc_w;

	always_comb begin
		n_tok   = tok_q;
		n_acc   = acc_q;
		n_in    = f_in_q;
		n_bad   = f_bad_q;
		n_dot   = f_dot_q;
		n_stop  = f_stop_q;
		n_frac  = frac_q;
		n_work  = work_q;
		n_run   = run_q;
		n_sstop = sstop_q;
		n_start = start_q;
		do_fin  = 1'b0;
		is_sep  = (reply_byte == 8'h20) ||
			(tok_q != 4'd0 && (reply_byte == 8'h0D || reply_byte == 8'h0A));
		is_digit = (reply_byte >= 8'h30) && (reply_byte <= 8'h39);
		dig     = reply_byte[3:0];
		acc_w   = '0;
		if (cmd.step) begin
			if (count_q == 7'd0) begin
				n_start = (reply_byte == 8'h28);
			end else if (start_q) begin
				if (is_sep) begin
					do_fin = f_in_q;
				end else begin
					if (!f_in_q) begin
						n_in = 1'b1; n_bad = 1'b0; n_dot = 1'b0;
						n_stop = 1'b0; n_frac = 2'd0; n_acc = '0;
					end
					if (tok_q < NumF) begin
						if (reply_byte == 8'h2E) begin
							if (n_dot) n_stop = 1'b1;
							else n_dot = 1'b1;
						end else if (is_digit) begin
							if (n_stop) begin
								n_acc = n_acc;
							end else if (!n_dot) begin
								acc_w = {4'd0, n_acc} * 24'd10 + 24'(dig) * 24'd100;
								n_acc = (acc_w > 24'(AccCap)) ? AccCap : acc_w[19:0];
							end else if (n_frac != 2'd2) begin
								n_acc  = n_acc + ((n_frac == 2'd0) ? 20'(dig) * 20'd10
									: 20'(dig));
								n_frac = n_frac + 2'd1;
							end
						end else begin
							n_bad = 1'b1;
						end
					end else if (tok_q == NumF && !sstop_q) begin
						if (reply_byte == 8'h30 || reply_byte == 8'h31) begin
							if (run_q < 4'd8 && reply_byte[0])
								n_work[run_q[2:0]] = 1'b1;
							if (run_q < 4'd9) n_run = run_q + 4'd1;
						end else begin
							n_sstop = 1'b1;
						end
					end
				end
			end
		end
		if (cmd.fin) do_fin = start_q && f_in_q;
		// token close
		wr_en  = do_fin && (tok_q < NumF) && !f_bad_q && (tok_q < 4'(KeptFields));
		wr_idx = tok_q[2:0];
		wr_val = (acc_q > ValueMax) ? ValueMax : acc_q;
		if (do_fin) begin
			if (tok_q != 4'd15) n_tok = tok_q + 4'd1;
			n_in = 1'b0; n_bad = 1'b0; n_dot = 1'b0; n_stop = 1'b0;
			n_frac = 2'd0; n_acc = '0;
		end
	end

	// result code of the finished reply
	logic [2:0] code_d;
	always_comb begin
		if (count_q < MinLen) code_d = RES_SHORT;
		else if (!start_q) code_d = RES_BADSTRT;
		else if (tok_q < NumF + 4'd1) code_d = RES_MISSING;
		else if (run_q != 4'd8) code_d = RES_BADSTAT;
		else code_d = RES_OK;
	end

	// battery scaling and charge setup
	logic [26:0] half_p;
	logic [19:0] bat_sat;
	logic        chg_ok;
	logic [19:0] bat_v, diff_v, rng_v;
	assign half_p  = prod_s1[27:1];
	assign bat_sat = (half_p > 27'(ValueMax)) ? ValueMax : half_p[19:0];
	assign chg_ok  = chgen_q && (low_q != 20'd0) && (high_q > low_q);
	assign bat_v   = committed_q[BatteryField];
	assign diff_v  = bat_v - low_q;
	assign rng_v   = high_q - low_q;

	assign sts.reject    = (code_d == RES_SHORT) || (code_d == RES_BADSTRT);
	assign sts.div_start = pvalid_q[BatteryField] && chg_ok && (bat_v > low_q)
		&& (bat_v < high_q);
	assign sts.div_last  = (dcnt_q == 5'd0);

	// divider step
	logic [21:0] trial;
	logic        qbit;
	assign trial = {rem_q, num_q[27]};
	assign qbit  = (trial >= {1'b0, den_q});

	// regulation classifier
	logic [27:0] vi, vo;
	logic [1:0]  mode_d;
	assign vi = 28'(committed_q[0]);
	assign vo = 28'(committed_q[2]);
	always_comb begin
		if ((vo << 1) < vi) mode_d = MODE_NONE;
		else if (vo * 28'd100 < vi * 28'd95) mode_d = MODE_TRIM;
		else if (vo * 28'd100 < vi * 28'd105) mode_d = MODE_BYPASS;
		else if ((vo << 1) < vi * 28'd3) mode_d = MODE_BOOST;
		else mode_d = MODE_NONE;
	end

	// pending store, no reset
	always_ff @(posedge clk) begin
		if (wr_en) pending_q[wr_idx] <= wr_val;
	end

	// payload registers of the commit steps
	always_ff @(posedge clk) begin
		if (cmd.eval) prod_s1 <= {8'd0, pending_q[BatteryField]} * {20'd0, pack_q};
		if (cmd.chg) begin
			num_q  <= 28'(diff_v) * 28'd200 + 28'(rng_v);
			den_q  <= {rng_v, 1'b0};
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (cmd.div) begin
			num_q <= {num_q[26:0], 1'b0};
			rem_q <= qbit ? 21'(trial - {1'b0, den_q}) : trial[20:0];
			quo_q <= {quo_q[5:0], qbit};
		end
	end

	// control and committed state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KeptFields; i++) committed_q[i] <= '0;
			pvalid_q  <= '0;
			count_q   <= '0;
			tok_q     <= '0;
			acc_q     <= '0;
			f_in_q    <= 1'b0;
			f_bad_q   <= 1'b0;
			f_dot_q   <= 1'b0;
			f_stop_q  <= 1'b0;
			frac_q    <= '0;
			work_q    <= '0;
			run_q     <= '0;
			sstop_q   <= 1'b0;
			start_q   <= 1'b0;
			code_q    <= RES_OK;
			capture_q <= '0;
			charge_q  <= '0;
			mode_q    <= MODE_NONE;
			dcnt_q    <= '0;
		end else if (cmd.clr) begin
			pvalid_q <= '0;
			count_q  <= '0;
			tok_q    <= '0;
			acc_q    <= '0;
			f_in_q   <= 1'b0;
			f_bad_q  <= 1'b0;
			f_dot_q  <= 1'b0;
			f_stop_q <= 1'b0;
			frac_q   <= '0;
			work_q   <= '0;
			run_q    <= '0;
			sstop_q  <= 1'b0;
			start_q  <= 1'b0;
		end else begin
			if (cmd.step && count_q != 7'd127) count_q <= count_q + 7'd1;
			tok_q    <= n_tok;
			acc_q    <= n_acc;
			f_in_q   <= n_in;
			f_bad_q  <= n_bad;
			f_dot_q  <= n_dot;
			f_stop_q <= n_stop;
			frac_q   <= n_frac;
			work_q   <= n_work;
			run_q    <= n_run;
			sstop_q  <= n_sstop;
			start_q  <= n_start;
			if (wr_en) pvalid_q[wr_idx] <= 1'b1;
			if (cmd.eval) begin
				code_q <= code_d;
				if (!sts.reject) begin
					for (int i = 0; i < KeptFields; i++)
						if (pvalid_q[i] && i != BatteryField) committed_q[i] <= pending_q[i];
				end
			end
			if (cmd.sat && pvalid_q[BatteryField]) committed_q[BatteryField] <= bat_sat;
			if (cmd.chg) begin
				dcnt_q <= 5'd27;
				if (pvalid_q[BatteryField] && chg_ok && !sts.div_start)
					charge_q <= {1'b1, (bat_v <= low_q) ? 7'd0 : 7'd100};
			end
			if (cmd.div) begin
				dcnt_q <= dcnt_q - 5'd1;
				if (sts.div_last) charge_q <= {1'b1, quo_q[5:0], qbit};
			end
			if (cmd.cls && code_q == RES_OK) begin
				capture_q <= work_q;
				mode_q    <= work_q[2] ? mode_d : MODE_NONE;
			end
		end
	end

	assign result_code       = code_q;
	assign line_voltage      = committed_q[0];
	assign fault_voltage     = committed_q[1];
	assign out_voltage       = committed_q[2];
	assign load_level        = committed_q[3];
	assign line_frequency    = committed_q[4];
	assign battery_volts     = committed_q[5];
	assign temperature_level = committed_q[6];
	assign charge_percent    = charge_q[6:0];
	assign charge_known      = charge_q[7];
	assign status_word       = capture_q;
	assign regulation_mode   = mode_q;

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: UPS status reply parser
// Sends status replies one byte per word with random gaps and output stalls,
// predicts every result word in a local model of the parser and compares
// it field by field. Covers directed corner replies, several configuration
// settings and a long random run of good, broken and noise replies.
// ---------------------------------------------------------------------------
module testbench;
	import ursp_pkg::*;

	localparam int NumFields  = NumFieldsDefault;
	localparam int MinBytes   = MinReplyDefault;
	localparam int IdleLimit  = 3000;
	localparam int DrainWait  = 40;
	localparam int ByteTarget = 1950;
	localparam int TailBytes  = 200;

	localparam int unsigned FL_IN   = 1;
	localparam int unsigned FL_BAD  = 2;
	localparam int unsigned FL_DOT  = 4;
	localparam int unsigned FL_STOP = 8;

	typedef struct {
		logic [2:0]  code;
		logic [19:0] vals [7];
		logic [6:0]  pct;
		logic        known;
		logic [7:0]  sw;
		logic [1:0]  mode;
	} status_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_PACK;
	logic [19:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  reply_byte = '0;
	logic        reply_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  result_code;
	logic [19:0] line_voltage, fault_voltage, out_voltage, load_level;
	logic [19:0] line_frequency, battery_volts, temperature_level;
	logic [6:0]  charge_percent;
	logic        charge_known;
	logic [7:0]  status_word;
	logic [1:0]  regulation_mode;

	ups_status_reply_parser_unit i_dut (.*);

	always #5 clk = ~clk;

	// model state
	int unsigned cfg_pack = 2, cfg_low = 0, cfg_high = 0, cfg_chg_en = 1;
	int unsigned kept_val [7];
	int unsigned parsed_val [7];
	int unsigned parsed_mask, byte_cnt, tok_idx, num_acc, tok_flags;
	int unsigned stat_capture, charge_reg, stat_bits, stat_run, reg_mode;
	bit          stat_stop, start_good;

	status_result_t expected_results [$];
	logic [7:0]     reply_buf [$];

	int  err_count, n_bytes, n_results;
	int  code_seen [5];
	int  mode_seen [4];
	bit  no_idle;
	int  hold_req, stall_left, idle_cycles;

	// --- parser model ---
	function automatic void clear_parse();
		parsed_mask = 0; byte_cnt = 0; tok_idx = 0; num_acc = 0; tok_flags = 0;
		stat_bits = 0; stat_run = 0; stat_stop = 0; start_good = 0;
	endfunction

	function automatic void take_char(logic [7:0] b);
		int unsigned d, fr;
		if (tok_idx < NumFields) begin
			if (b == ".") begin
				tok_flags |= (tok_flags & FL_DOT) ? FL_STOP : FL_DOT;
			end else if (b >= "0" && b <= "9") begin
				d = b - "0";
				if (tok_flags & FL_STOP) begin
				end else if (!(tok_flags & FL_DOT)) begin
					num_acc = num_acc * 10 + 100 * d;
					if (num_acc > AccCap) num_acc = AccCap;
				end else begin
					fr = (tok_flags >> 4) & 3;
					if (fr < 2) begin
						num_acc += (fr == 0) ? 10 * d : d;
						tok_flags = (tok_flags & 15) | ((fr + 1) << 4);
					end
				end
			end else begin
				tok_flags |= FL_BAD;
			end
		end else if (tok_idx == NumFields && !stat_stop) begin
			if (b == "0" || b == "1") begin
				if (stat_run < 8 && b == "1") stat_bits |= 1 << stat_run;
				if (stat_run < 9) stat_run++;
			end else begin
				stat_stop = 1;
			end
		end
	endfunction

	function automatic void close_token();
		if (tok_idx < NumFields && !(tok_flags & FL_BAD) && tok_idx < KeptFields) begin
			parsed_val[tok_idx] = (num_acc > ValueMax) ? ValueMax : num_acc;
			parsed_mask |= 1 << tok_idx;
		end
		if (tok_idx < 15) tok_idx++;
		tok_flags = 0;
		num_acc = 0;
	endfunction

	function automatic void commit_parsed();
		longint unsigned prod, span;
		int unsigned v, pct;
		for (int i = 0; i < KeptFields; i++) begin
			if (!parsed_mask[i]) continue;
			if (i == BatteryField) begin
				prod = longint'(parsed_val[i]) * cfg_pack / 2;
				v = (prod > ValueMax) ? ValueMax : int'(prod);
				kept_val[i] = v;
				if (cfg_chg_en != 0 && cfg_low > 0 && cfg_high > cfg_low) begin
					if (v <= cfg_low) pct = 0;
					else if (v >= cfg_high) pct = 100;
					else begin
						span = cfg_high - cfg_low;
						pct = int'((200 * longint'(v - cfg_low) + span) / (2 * span));
					end
					charge_reg = 32'h80 | pct;
				end
			end else begin
				kept_val[i] = parsed_val[i];
			end
		end
	endfunction

	function automatic int unsigned regulation_of();
		longint unsigned vi, vo;
		vi = kept_val[0];
		vo = kept_val[2];
		if (2 * vo < vi) return MODE_NONE;
		if (100 * vo < 95 * vi) return MODE_TRIM;
		if (100 * vo < 105 * vi) return MODE_BYPASS;
		if (2 * vo < 3 * vi) return MODE_BOOST;
		return MODE_NONE;
	endfunction

	// advance the model by one accepted word, queue a result on the end byte
	function automatic void predict_word(logic [7:0] b, logic last);
		int unsigned pos;
		bit sep;
		status_result_t r;
		pos = byte_cnt;
		if (byte_cnt < 127) byte_cnt++;
		if (pos == 0) begin
			start_good = (b == "(");
		end else if (start_good) begin
			sep = (b == " ") || (tok_idx > 0 && (b == 8'h0d || b == 8'h0a));
			if (sep) begin
				if (tok_flags & FL_IN) close_token();
			end else begin
				if (!(tok_flags & FL_IN)) begin
					tok_flags = FL_IN;
					num_acc = 0;
				end
				take_char(b);
			end
		end
		if (!last) return;
		if (start_good && (tok_flags & FL_IN)) close_token();
		if (byte_cnt < MinBytes) r.code = RES_SHORT;
		else if (!start_good) r.code = RES_BADSTRT;
		else begin
			commit_parsed();
			if (tok_idx < NumFields + 1) r.code = RES_MISSING;
			else if (stat_run != 8) r.code = RES_BADSTAT;
			else begin
				r.code = RES_OK;
				stat_capture = stat_bits & 255;
				reg_mode = stat_capture[2] ? regulation_of() : MODE_NONE;
			end
		end
		for (int i = 0; i < 7; i++) r.vals[i] = kept_val[i][19:0];
		r.pct = charge_reg[6:0];
		r.known = charge_reg[7];
		r.sw = stat_capture[7:0];
		r.mode = reg_mode[1:0];
		expected_results.push_back(r);
		clear_parse();
	endfunction

	// --- checking ---
	task automatic report_mismatch(string what, int got, int want);
		err_count++;
		$display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want, n_results);
	endtask

	task automatic check_field(string what, int got, int want);
		if (got != want) report_mismatch(what, got, want);
	endtask

	task automatic check_result();
		status_result_t w;
		if (expected_results.size() == 0) begin
			report_mismatch("unexpected result word", result_code, -1);
			return;
		end
		w = expected_results.pop_front();
		check_field("result_code", result_code, w.code);
		check_field("line_voltage", line_voltage, w.vals[0]);
		check_field("fault_voltage", fault_voltage, w.vals[1]);
		check_field("out_voltage", out_voltage, w.vals[2]);
		check_field("load_level", load_level, w.vals[3]);
		check_field("line_frequency", line_frequency, w.vals[4]);
		check_field("battery_volts", battery_volts, w.vals[5]);
		check_field("temperature_level", temperature_level, w.vals[6]);
		check_field("charge_percent", charge_percent, w.pct);
		check_field("charge_known", charge_known, w.known);
		check_field("status_word", status_word, w.sw);
		check_field("regulation_mode", regulation_mode, w.mode);
		code_seen[w.code]++;
		mode_seen[w.mode]++;
		n_results++;
	endtask

	// receiver: random stalls per word, plus long holds on request
	always @(posedge clk) begin
		if (out_valid === 1'b1 && !out_stall) begin
			check_result();
			stall_left = no_idle ? 0 : $urandom_range(0, 4);
		end
		if (hold_req > 0) begin
			stall_left = hold_req;
			hold_req = 0;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles with no accepted word on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("timeout: no word accepted for %0d cycles", IdleLimit);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// --- sending ---
	task automatic send_word(logic [7:0] b, logic last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		reply_byte <= b;
		reply_end <= last;
		do @(posedge clk); while (in_stall);
		predict_word(b, last);
		n_bytes++;
	endtask

	task automatic send_reply();
		for (int i = 0; i < reply_buf.size(); i++)
			send_word(reply_buf[i], i == reply_buf.size() - 1);
		reply_buf.delete();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, int unsigned data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[19:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PACK:  cfg_pack = data & 255;
			REG_LOW:   cfg_low = data & 20'hFFFFF;
			REG_HIGH:  cfg_high = data & 20'hFFFFF;
			REG_CHGEN: cfg_chg_en = data & 1;
			default: ;
		endcase
	endtask

	task automatic set_config(int unsigned pack, int unsigned low, int unsigned high,
			int unsigned en);
		drain();
		cfg_write(REG_PACK, pack);
		cfg_write(REG_LOW, low);
		cfg_write(REG_HIGH, high);
		cfg_write(REG_CHGEN, en);
	endtask

	// --- reply builders ---
	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) reply_buf.push_back(s[i]);
	endtask

	function automatic string num_text(int unsigned v, int frac);
		if (frac == 0) return $sformatf("%0d", v / 100);
		if (frac == 1) return $sformatf("%0d.%0d", v / 100, (v % 100) / 10);
		return $sformatf("%0d.%02d", v / 100, v % 100);
	endfunction

	function automatic string status_text(logic [7:0] sw);
		string s;
		s = "";
		for (int i = 0; i < 8; i++) s = {s, sw[i] ? "1" : "0"};
		return s;
	endfunction

	// well-formed reply with the given values in hundredths
	task automatic add_good(int unsigned vi, int unsigned vo, int unsigned batt,
			logic [7:0] sw);
		int unsigned v [7];
		v = '{vi, $urandom_range(0, 30000), vo, $urandom_range(0, 12000),
			$urandom_range(4000, 6500), batt, $urandom_range(0, 9000)};
		add_text("(");
		for (int i = 0; i < 7; i++) begin
			add_text(num_text(v[i], $urandom_range(0, 2)));
			add_text(($urandom_range(0, 7) == 0) ? "  " : " ");
		end
		add_text(status_text(sw));
		while (reply_buf.size() < MinBytes + 1) add_text(" ");
		if ($urandom_range(0, 3) == 0) add_text("\r");
	endtask

	function automatic int unsigned battery_raw();
		int unsigned target, raw;
		target = (cfg_high > 0 && $urandom_range(0, 3) != 0)
			? $urandom_range(cfg_low / 2, cfg_high + cfg_high / 8) : $urandom_range(0, 99999);
		if (target > ValueMax) target = ValueMax;
		raw = (cfg_pack == 0) ? target : target * 2 / cfg_pack;
		return (raw > ValueMax) ? ValueMax : raw;
	endfunction

	task automatic add_random_good();
		int unsigned vi;
		vi = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 30000);
		add_good(vi, vi * $urandom_range(30, 160) / 100, battery_raw(), 8'($urandom()));
	endtask

	task automatic add_random_reply();
		int kind, n;
		kind = $urandom_range(0, 15);
		if (kind < 9) begin
			add_random_good();
		end else if (kind == 9) begin
			add_random_good();
			reply_buf[0] = 8'($urandom_range(0, 255));
		end else if (kind == 10) begin
			add_random_good();
			n = $urandom_range(1, reply_buf.size() - 1);
			while (reply_buf.size() > n) void'(reply_buf.pop_back());
		end else if (kind == 11) begin
			add_random_good();
			reply_buf[$urandom_range(1, reply_buf.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (kind == 12) begin
			add_random_good();
			add_text($urandom_range(0, 1) ? " 1 2" : "1");
		end else if (kind == 13) begin
			add_text("(");
			repeat ($urandom_range(8, 12)) begin
				repeat ($urandom_range(1, 6))
					reply_buf.push_back(8'(($urandom_range(0, 3) == 0) ? "."
						: "0" + $urandom_range(0, 9)));
				add_text($urandom_range(0, 4) == 0 ? "\n" : " ");
			end
		end else begin
			add_text($urandom_range(0, 1) ? "(" : "");
			repeat ($urandom_range(1, 70)) reply_buf.push_back(8'($urandom_range(0, 255)));
		end
		send_reply();
	endtask

	// --- tests ---
	task automatic test_directed();
		// exact regulation thresholds: half, 0.95, 1.05 and 1.5 of line
		add_good(20000, 10000, 2400, 8'h04); send_reply();
		add_good(20000, 19000, 2400, 8'h04); send_reply();
		add_good(20000, 20999, 2400, 8'h04); send_reply();
		add_good(20000, 21000, 2400, 8'h04); send_reply();
		add_good(20000, 29999, 2400, 8'h04); send_reply();
		add_good(20000, 30000, 2400, 8'hFF); send_reply();
		add_good(20000, 18999, 2400, 8'h00); send_reply();
		// saturation, dots only, second dot, zero byte, CR in first token
		add_text("(99999999.999 ... 1.2.34 12.345 1");
		reply_buf.push_back(8'h00);
		add_text(" 9999.99 .5 11111111 x\n"); send_reply();
		add_text("(230.0\r 1 2 3 4 5 6 00000000            \r"); send_reply();
		// short, bad start, missing token, bad status words, extra tokens
		add_text("(1 2 3 4 5 6 7 00000000"); send_reply();
		add_text("[230.0 140.0 230.0 013 50.0 2.27 48.0 00001001    "); send_reply();
		add_text("(230.0 140.0 230.0 013 50.0 2.27 48.0               "); send_reply();
		add_text("(230.0 140.0 230.0 013 50.0 2.27 48.0 0000100     "); send_reply();
		add_text("(230.0 140.0 230.0 013 50.0 2.27 48.0 000010011   "); send_reply();
		add_text("(230.0 140.0 230.0 013 50.0 2.27 48.0 00001001x 7 8"); send_reply();
		add_text("(230.0 14a.0 230.0 013 50.0 2.27 48.0 0000100A    "); send_reply();
	endtask

	task automatic test_config_extremes();
		set_config(2, 4000, 5400, 1);
		repeat (3) add_random_reply();
		set_config(1, 1, 999999, 1);
		repeat (3) add_random_reply();
		set_config(240, 2000, 2700, 1);
		add_good(20000, 20000, 999999, 8'h04); send_reply();
		repeat (2) add_random_reply();
		set_config(3, 1200, 1000, 1);
		repeat (2) add_random_reply();
		set_config(4, 1000, 1400, 0);
		repeat (2) add_random_reply();
	endtask

	task automatic test_backpressure();
		drain();
		no_idle = 1;
		hold_req = 300;
		repeat (3) begin
			add_random_good();
			send_reply();
		end
		no_idle = 0;
		drain();
	endtask

	// leaves room for the closing replies sent after it
	task automatic test_random_replies();
		while (n_bytes < ByteTarget - TailBytes) begin
			if ($urandom_range(0, 7) == 0)
				set_config($urandom_range(1, 240), $urandom_range(0, 60000),
					$urandom_range(0, 80000), $urandom_range(0, 1));
			no_idle = ($urandom_range(0, 4) == 0);
			add_random_reply();
		end
		no_idle = 0;
	endtask

	initial begin
		clear_parse();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_backpressure();
		test_random_replies();
		set_config(2, 0, 0, 1);
		repeat (4) add_random_reply();
		drain();
		$display("covered %0d reply bytes, %0d results: ok %0d short %0d bad start %0d",
			n_bytes, n_results, code_seen[RES_OK], code_seen[RES_SHORT], code_seen[RES_BADSTRT]);
		$display("missing token %0d bad status %0d; modes trim %0d bypass %0d boost %0d",
			code_seen[RES_MISSING], code_seen[RES_BADSTAT], mode_seen[MODE_TRIM],
			mode_seen[MODE_BYPASS], mode_seen[MODE_BOOST]);
		if (err_count == 0 && expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
